// File: src/i2da_pkg.sv
// i2da_pkg: shared types and constants for the binary to decimal ASCII converter.
// No dependencies.

package i2da_pkg;

   // Sequencer states, one-hot.
   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_CONV = 5'b00010,
      ST_SCAN = 5'b00100,
      ST_PAD  = 5'b01000,
      ST_EMIT = 5'b10000
   } state_type;

   // Field widths of the item and result.
   localparam int unsigned VALUE_BITS = 32;
   localparam int unsigned MIN_BITS   = 5;
   localparam int unsigned CHAR_BITS  = 6;

   localparam logic [CHAR_BITS-1:0] ASCII_ZERO = 6'd48;

   typedef logic [3:0] bcd_digit_type;

endpackage

// File: src/int_to_decimal_ascii.sv
// int_to_decimal_ascii: unsigned binary to zero-padded decimal ASCII digit stream.
// Depends on i2da_pkg and i2da_dabble.
//
// Channel  | Ports                               | Handshake
// ---------+-------------------------------------+----------------------------------
// request  | req_value, req_min_digits           | taken when start & !busy
// response | rsp_digit_char, rsp_last            | one cycle each, rsp_valid strobe
//
// Sequence: a load, then one conversion step per value bit (shared shift-add-3 unit),
// then a leading-zero scan and pad decision, then one cycle per emitted digit
// (max(nsig, min_digits clamped to MAX_DIGITS)). The worst case for a 32-bit value
// is zero padded to 16 digits, which gives the longest scan and the longest output.
// busy stays high from acceptance until the last digit is issued; that digit is on the
// ports in the first idle cycle. Reset is synchronous and returns the sequencer to idle;
// data registers are not cleared. The receiver cannot stall: each digit is shown for
// exactly one cycle.

module int_to_decimal_ascii #(
   parameter int unsigned MAX_DIGITS  = 16,
   parameter int unsigned VALUE_WIDTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [i2da_pkg::VALUE_BITS-1:0]     req_value,
   input  logic [i2da_pkg::MIN_BITS-1:0]       req_min_digits,
   output logic                                rsp_valid,
   output logic [i2da_pkg::CHAR_BITS-1:0]      rsp_digit_char,
   output logic                                rsp_last
);
   import i2da_pkg::*;

   // Decimal digits of 2^VALUE_WIDTH-1: floor(W*log10(2))+1.
   localparam int unsigned BCD_DIGITS = (VALUE_WIDTH * 30103) / 100000 + 1;
   localparam int unsigned BCD_W      = 4 * BCD_DIGITS;
   localparam int unsigned CNT_W      = $clog2(VALUE_WIDTH + 1);
   localparam int unsigned NSIG_W     = $clog2(BCD_DIGITS + 1);
   localparam int unsigned WANT_W     = $clog2(MAX_DIGITS + 1);

   state_type          state_ff, state_in;
   logic [VALUE_WIDTH-1:0] bin_ff, bin_in;
   logic [BCD_W-1:0]   bcd_ff, bcd_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [NSIG_W-1:0]  nsig_ff, nsig_in;
   logic [WANT_W-1:0]  want_ff, want_in;
   logic [WANT_W-1:0]  pad_ff, pad_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [CHAR_BITS-1:0] rsp_char_ff, rsp_char_in;
   logic               rsp_last_ff, rsp_last_in;

   logic [BCD_W-1:0]        step_bcd;
   logic [VALUE_WIDTH-1:0]  step_bin;
   bcd_digit_type           top_digit;
   logic [WANT_W-1:0]       nsig_ext;
   logic [WANT_W-1:0]       want_clamped;

   // Shared shift-add-3 step.
   i2da_dabble #(
      .BIN_W (VALUE_WIDTH),
      .NDIG  (BCD_DIGITS)
   ) u_dabble (
      .bcd      (bcd_ff),
      .bin      (bin_ff),
      .bcd_next (step_bcd),
      .bin_next (step_bin)
   );

   assign top_digit = bcd_ff[BCD_W-1 -: 4];
   assign nsig_ext  = WANT_W'(nsig_ff);

   // Clamp the requested minimum at MAX_DIGITS.
   always_comb begin
      if (32'(req_min_digits) > MAX_DIGITS) begin
         want_clamped = WANT_W'(MAX_DIGITS);
      end else begin
         want_clamped = WANT_W'(req_min_digits);
      end
   end

   always_comb begin
      state_in     = state_ff;
      bin_in       = bin_ff;
      bcd_in       = bcd_ff;
      cnt_in       = cnt_ff;
      nsig_in      = nsig_ff;
      want_in      = want_ff;
      pad_in       = pad_ff;
      rsp_valid_in = 1'b0;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               bin_in   = req_value[VALUE_WIDTH-1:0];
               bcd_in   = '0;
               cnt_in   = CNT_W'(VALUE_WIDTH);
               want_in  = want_clamped;
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            // One input bit shifted into the BCD register per cycle.
            bcd_in = step_bcd;
            bin_in = step_bin;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               nsig_in  = NSIG_W'(BCD_DIGITS);
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // Drop leading zero digits, keeping at least one.
            if (top_digit == 4'd0 && nsig_ff > NSIG_W'(1)) begin
               bcd_in  = {bcd_ff[BCD_W-5:0], 4'd0};
               nsig_in = nsig_ff - 1'b1;
            end else if (want_ff > nsig_ext) begin
               pad_in   = want_ff - nsig_ext;
               state_in = ST_PAD;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_PAD: begin
            // Padding zeros; never the last digit since nsig is at least one.
            rsp_valid_in = 1'b1;
            rsp_char_in  = ASCII_ZERO;
            pad_in       = pad_ff - 1'b1;
            if (pad_ff == WANT_W'(1)) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            rsp_valid_in = 1'b1;
            rsp_char_in  = ASCII_ZERO + CHAR_BITS'(top_digit);
            rsp_last_in  = (nsig_ff == NSIG_W'(1));
            bcd_in       = {bcd_ff[BCD_W-5:0], 4'd0};
            nsig_in      = nsig_ff - 1'b1;
            if (nsig_ff == NSIG_W'(1)) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         rsp_last_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_last_ff  <= rsp_last_in;
      end
   end

   always_ff @(posedge clock) begin
      bin_ff      <= bin_in;
      bcd_ff      <= bcd_in;
      cnt_ff      <= cnt_in;
      nsig_ff     <= nsig_in;
      want_ff     <= want_in;
      pad_ff      <= pad_in;
      rsp_char_ff <= rsp_char_in;
   end

   assign busy           = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_digit_char = rsp_char_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

// File: src/i2da_dabble.sv
// i2da_dabble: one shift-add-3 step of the binary to BCD conversion.
// Depends on i2da_pkg.

module i2da_dabble #(
   parameter int unsigned BIN_W = 32,
   parameter int unsigned NDIG  = 10
) (
   input  logic [4*NDIG-1:0] bcd,
   input  logic [BIN_W-1:0]  bin,
   output logic [4*NDIG-1:0] bcd_next,
   output logic [BIN_W-1:0]  bin_next
);
   import i2da_pkg::*;

   logic [4*NDIG-1:0] adj;

   // Add 3 to every digit of 5 or more so that the shift carries correctly.
   always_comb begin
      bcd_digit_type d;
      adj = '0;
      for (int i = 0; i < NDIG; i++) begin
         d = bcd[4*i +: 4];
         adj[4*i +: 4] = (d >= 4'd5) ? d + 4'd3 : d;
      end
   end

   assign bcd_next = {adj[4*NDIG-2:0], bin[BIN_W-1]};
   assign bin_next = {bin[BIN_W-2:0], 1'b0};

endmodule
